FILE: design/rct_pkg.sv
// shared widths, status codes and sideband types for the ray/circle time-to-hit block
package rct_pkg;

  // field widths
  localparam int CB  = 16;  // coordinate bits
  localparam int F   = 8;   // fraction bits of the time
  localparam int RB  = 15;  // radius bits
  localparam int TB  = 24;  // time bits
  localparam int SB  = 2;   // status bits

  // derived datapath widths
  localparam int DB  = CB + 1;                      // signed point-minus-center
  localparam int D2B = 2 * CB + 1;                  // squared distance
  localparam int R2B = 2 * RB;                      // squared radius
  localparam int KB  = (D2B > R2B) ? D2B : R2B;     // distance excess
  localparam int AB  = 2 * CB;                      // squared speed
  localparam int HSB = 2 * CB + 2;                  // signed dot product
  localparam int HMB = 2 * CB;                      // magnitude of a negative dot product
  localparam int HHB = 2 * HMB;                     // dot product squared
  localparam int AKB = AB + KB;                     // speed squared times excess
  localparam int PB  = (HHB > AKB) ? HHB : AKB;     // discriminant compare width
  localparam int RDB = HHB;                         // square root radicand
  localparam int SQB = HMB;                         // square root result
  localparam int RMB = SQB + 2;                     // square root partial remainder
  localparam int NB  = HMB + F;                     // scaled dividend

  localparam logic [TB-1:0] TIME_MAX = {TB{1'b1}};

  typedef enum logic [SB-1:0] {
    ST_CONTACT = 2'd0,
    ST_HIT     = 2'd1,
    ST_NEVER   = 2'd2
  } status_t;

  // data that rides along the square root pipeline
  typedef struct packed {
    status_t          status;
    logic [HMB-1:0]   hm;
    logic [AB-1:0]    a;
  } sqrt_side_t;

endpackage

FILE: design/rct_query_if.sv
// query channel: point, velocity and circle
interface rct_query_if;
  import rct_pkg::*;

  logic                 valid;
  logic                 ready;
  logic signed [CB-1:0] point_x;
  logic signed [CB-1:0] point_y;
  logic signed [CB-1:0] vel_x;
  logic signed [CB-1:0] vel_y;
  logic signed [CB-1:0] circle_center_x;
  logic signed [CB-1:0] circle_center_y;
  logic [RB-1:0]        circle_radius;

  modport source (
    output valid, point_x, point_y, vel_x, vel_y, circle_center_x, circle_center_y,
           circle_radius,
    input  ready
  );
  modport sink (
    input  valid, point_x, point_y, vel_x, vel_y, circle_center_x, circle_center_y,
           circle_radius,
    output ready
  );
endinterface

FILE: design/rct_result_if.sv
// result channel: hit status and time to first contact
interface rct_result_if;
  import rct_pkg::*;

  logic          valid;
  logic          ready;
  logic [SB-1:0] hit_status;
  logic [TB-1:0] time_to_hit;

  modport source (output valid, hit_status, time_to_hit, input ready);
  modport sink (input valid, hit_status, time_to_hit, output ready);
endinterface

FILE: design/rct_sqrt_pipe.sv
// pipelined floor square root, one result bit per stage
module rct_sqrt_pipe (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic [rct_pkg::RDB-1:0]   radicand,
  input  rct_pkg::sqrt_side_t       side_in,
  output logic                      out_valid,
  output logic [rct_pkg::SQB-1:0]   root,
  output rct_pkg::sqrt_side_t       side_out
);
  import rct_pkg::*;

  logic             vld_r  [SQB];
  logic [RDB-1:0]   x_r    [SQB];
  logic [RMB-1:0]   rem_r  [SQB];
  logic [SQB-1:0]   root_r [SQB];
  sqrt_side_t       side_r [SQB];

  for (genvar g = 0; g < SQB; g++) begin : g_stage
    logic             v_in;
    logic [RDB-1:0]   x_in;
    logic [RMB-1:0]   rem_in;
    logic [SQB-1:0]   root_in;
    sqrt_side_t       s_in;
    logic [RMB-1:0]   cur;
    logic [RMB-1:0]   trial;
    logic             ge;

    // stage inputs
    if (g == 0) begin : g_first
      assign v_in    = in_valid;
      assign x_in    = radicand;
      assign rem_in  = '0;
      assign root_in = '0;
      assign s_in    = side_in;
    end else begin : g_next
      assign v_in    = vld_r[g-1];
      assign x_in    = x_r[g-1];
      assign rem_in  = rem_r[g-1];
      assign root_in = root_r[g-1];
      assign s_in    = side_r[g-1];
    end

    // bring down two radicand bits and try the next root bit
    assign cur   = {rem_in[SQB-1:0], x_in[RDB-1 -: 2]};
    assign trial = {root_in, 2'b01};
    assign ge    = (cur >= trial);

    // valid bit
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g] <= 1'b0;
      end else if (en) begin
        vld_r[g] <= v_in;
      end
    end

    // stage data
    always_ff @(posedge clk) begin
      if (en) begin
        x_r[g]    <= x_in << 2;
        rem_r[g]  <= ge ? (cur - trial) : cur;
        root_r[g] <= {root_in[SQB-2:0], ge};
        side_r[g] <= s_in;
      end
    end
  end

  assign out_valid = vld_r[SQB-1];
  assign root      = root_r[SQB-1];
  assign side_out  = side_r[SQB-1];
endmodule

FILE: design/rct_div_pipe.sv
// pipelined restoring divider, one quotient bit per stage, saturating quotient
module rct_div_pipe (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic [rct_pkg::HMB-1:0]   dividend,
  input  logic [rct_pkg::AB-1:0]    divisor,
  input  rct_pkg::status_t          status_in,
  output logic                      out_valid,
  output logic [rct_pkg::TB-1:0]    quotient,
  output rct_pkg::status_t          status_out
);
  import rct_pkg::*;

  logic             vld_r  [NB];
  logic [NB-1:0]    num_r  [NB];
  logic [AB:0]      rem_r  [NB];
  logic [TB-1:0]    q_r    [NB];
  logic             sat_r  [NB];
  logic [AB-1:0]    a_r    [NB];
  status_t          st_r   [NB];

  for (genvar g = 0; g < NB; g++) begin : g_stage
    logic             v_in;
    logic [NB-1:0]    num_in;
    logic [AB:0]      rem_in;
    logic [TB-1:0]    q_in;
    logic             sat_in;
    logic [AB-1:0]    a_in;
    status_t          st_in;
    logic [AB:0]      cur;
    logic [AB:0]      dsr;
    logic             ge;

    // stage inputs
    if (g == 0) begin : g_first
      assign v_in   = in_valid;
      assign num_in = NB'(dividend) << F;
      assign rem_in = '0;
      assign q_in   = '0;
      assign sat_in = 1'b0;
      assign a_in   = divisor;
      assign st_in  = status_in;
    end else begin : g_next
      assign v_in   = vld_r[g-1];
      assign num_in = num_r[g-1];
      assign rem_in = rem_r[g-1];
      assign q_in   = q_r[g-1];
      assign sat_in = sat_r[g-1];
      assign a_in   = a_r[g-1];
      assign st_in  = st_r[g-1];
    end

    // shift in the next dividend bit and try a subtract
    assign cur = {rem_in[AB-1:0], num_in[NB-1]};
    assign dsr = {1'b0, a_in};
    assign ge  = (cur >= dsr);

    // valid bit
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g] <= 1'b0;
      end else if (en) begin
        vld_r[g] <= v_in;
      end
    end

    // stage data; a one shifted out of the quotient means saturation
    always_ff @(posedge clk) begin
      if (en) begin
        num_r[g] <= num_in << 1;
        rem_r[g] <= ge ? (cur - dsr) : cur;
        q_r[g]   <= {q_in[TB-2:0], ge};
        sat_r[g] <= sat_in | q_in[TB-1];
        a_r[g]   <= a_in;
        st_r[g]  <= st_in;
      end
    end
  end

  assign out_valid  = vld_r[NB-1];
  assign quotient   = sat_r[NB-1] ? TIME_MAX : q_r[NB-1];
  assign status_out = st_r[NB-1];
endmodule

FILE: design/ray_circle_time_to_hit.sv
// top level: time for a moving point to reach a circle
//
//   port     | dir  | carries
//   ---------+------+-------------------------------------------------
//   in_chan  | sink | point, velocity, circle center and radius
//   out_chan | src  | hit status and time to hit (unsigned Q16.8)
//
// one query per cycle sustained while out_chan is not stalled; the pipeline holds
// 5 setup stages, 32 square root stages, 1 numerator stage, 40 divider stages, output
// the pipeline depth is set by one bit per stage of square root and division
// out_chan stall freezes the whole pipeline; in_chan.ready drops with it
// reset clears the valid bits only
module ray_circle_time_to_hit (
  input logic         clk,
  input logic         rst_n,
  rct_query_if.sink   in_chan,
  rct_result_if.source out_chan
);
  import rct_pkg::*;

  logic en;

  // stage 1: offsets
  logic                 s1_vld_r;
  logic signed [DB-1:0] s1_dx_r, s1_dy_r;
  logic signed [CB-1:0] s1_vx_r, s1_vy_r;
  logic [RB-1:0]        s1_r_r;

  // stage 2: squares and dot product
  logic                  s2_vld_r;
  logic [D2B-1:0]        s2_dist2_r;
  logic [R2B-1:0]        s2_r2_r;
  logic [AB-1:0]         s2_a_r;
  logic signed [HSB-1:0] s2_h_r;

  // stage 3: classification
  logic           s3_vld_r;
  status_t        s3_st_r;
  logic [KB-1:0]  s3_k_r;
  logic [HMB-1:0] s3_hm_r;
  logic [AB-1:0]  s3_a_r;

  // stage 4: discriminant products
  logic           s4_vld_r;
  status_t        s4_st_r;
  logic [HHB-1:0] s4_hh_r;
  logic [AKB-1:0] s4_ak_r;
  logic [HMB-1:0] s4_hm_r;
  logic [AB-1:0]  s4_a_r;

  // stage 5: discriminant
  logic           s5_vld_r;
  logic [RDB-1:0] s5_disc_r;
  sqrt_side_t     s5_side_r;

  // square root outputs
  logic           sq_vld;
  logic [SQB-1:0] sq_root;
  sqrt_side_t     sq_side;

  // stage 6: numerator
  logic           s6_vld_r;
  logic [HMB-1:0] s6_n_r;
  logic [AB-1:0]  s6_a_r;
  status_t        s6_st_r;

  // divider outputs
  logic          dv_vld;
  logic [TB-1:0] dv_q;
  status_t       dv_st;

  // output register
  logic          out_vld_r;
  status_t       out_st_r;
  logic [TB-1:0] out_time_r;

  // combinational products
  logic signed [2*DB-1:0] dxx, dyy;
  logic signed [AB-1:0]   vxx, vyy;
  logic signed [HSB-1:0]  hx, hy;
  logic [HSB-1:0]         hneg;
  logic [PB-1:0]          hh_ext, ak_ext, disc_full;

  // whole pipeline advances unless a finished result is held
  assign en            = !out_vld_r || out_chan.ready;
  assign in_chan.ready = en;

  // valid bits of the local stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      s3_vld_r  <= 1'b0;
      s4_vld_r  <= 1'b0;
      s5_vld_r  <= 1'b0;
      s6_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r  <= in_chan.valid;
      s2_vld_r  <= s1_vld_r;
      s3_vld_r  <= s2_vld_r;
      s4_vld_r  <= s3_vld_r;
      s5_vld_r  <= s4_vld_r;
      s6_vld_r  <= sq_vld;
      out_vld_r <= dv_vld;
    end
  end

  // stage 1
  always_ff @(posedge clk) begin
    if (en) begin
      s1_dx_r <= DB'(in_chan.point_x) - DB'(in_chan.circle_center_x);
      s1_dy_r <= DB'(in_chan.point_y) - DB'(in_chan.circle_center_y);
      s1_vx_r <= in_chan.vel_x;
      s1_vy_r <= in_chan.vel_y;
      s1_r_r  <= in_chan.circle_radius;
    end
  end

  // stage 2 products
  assign dxx = s1_dx_r * s1_dx_r;
  assign dyy = s1_dy_r * s1_dy_r;
  assign vxx = AB'(s1_vx_r) * AB'(s1_vx_r);
  assign vyy = AB'(s1_vy_r) * AB'(s1_vy_r);
  assign hx  = HSB'(s1_dx_r) * HSB'(s1_vx_r);
  assign hy  = HSB'(s1_dy_r) * HSB'(s1_vy_r);

  always_ff @(posedge clk) begin
    if (en) begin
      s2_dist2_r <= dxx[D2B-1:0] + dyy[D2B-1:0];
      s2_r2_r    <= R2B'(s1_r_r) * R2B'(s1_r_r);
      s2_a_r     <= vxx + vyy;
      s2_h_r     <= hx + hy;
    end
  end

  // stage 3: contact, standing still, moving away
  assign hneg = -s2_h_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (KB'(s2_dist2_r) <= KB'(s2_r2_r)) begin
        s3_st_r <= ST_CONTACT;
      end else if (s2_a_r == '0 || !s2_h_r[HSB-1]) begin
        s3_st_r <= ST_NEVER;
      end else begin
        s3_st_r <= ST_HIT;
      end
      s3_k_r  <= KB'(s2_dist2_r) - KB'(s2_r2_r);
      s3_hm_r <= hneg[HMB-1:0];
      s3_a_r  <= s2_a_r;
    end
  end

  // stage 4: h squared and a times k
  always_ff @(posedge clk) begin
    if (en) begin
      s4_st_r <= s3_st_r;
      s4_hh_r <= HHB'(s3_hm_r) * HHB'(s3_hm_r);
      s4_ak_r <= AKB'(s3_a_r) * AKB'(s3_k_r);
      s4_hm_r <= s3_hm_r;
      s4_a_r  <= s3_a_r;
    end
  end

  // stage 5: discriminant, negative means a miss
  assign hh_ext    = PB'(s4_hh_r);
  assign ak_ext    = PB'(s4_ak_r);
  assign disc_full = hh_ext - ak_ext;

  always_ff @(posedge clk) begin
    if (en) begin
      s5_disc_r      <= disc_full[RDB-1:0];
      s5_side_r.hm   <= s4_hm_r;
      s5_side_r.a    <= s4_a_r;
      if (s4_st_r == ST_HIT && hh_ext < ak_ext) begin
        s5_side_r.status <= ST_NEVER;
      end else begin
        s5_side_r.status <= s4_st_r;
      end
    end
  end

  rct_sqrt_pipe u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s5_vld_r),
    .radicand  (s5_disc_r),
    .side_in   (s5_side_r),
    .out_valid (sq_vld),
    .root      (sq_root),
    .side_out  (sq_side)
  );

  // stage 6: numerator of the time to the first contact
  always_ff @(posedge clk) begin
    if (en) begin
      s6_n_r  <= sq_side.hm - sq_root;
      s6_a_r  <= sq_side.a;
      s6_st_r <= sq_side.status;
    end
  end

  rct_div_pipe u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_valid   (s6_vld_r),
    .dividend   (s6_n_r),
    .divisor    (s6_a_r),
    .status_in  (s6_st_r),
    .out_valid  (dv_vld),
    .quotient   (dv_q),
    .status_out (dv_st)
  );

  // output register, time only for a hit
  always_ff @(posedge clk) begin
    if (en) begin
      out_st_r   <= dv_st;
      out_time_r <= (dv_st == ST_HIT) ? dv_q : '0;
    end
  end

  assign out_chan.valid       = out_vld_r;
  assign out_chan.hit_status  = out_st_r;
  assign out_chan.time_to_hit = out_time_r;
endmodule

FILE: sim/ray_circle_time_to_hit_tb.sv
// testbench for the ray/circle time-to-hit block: directed and random queries checked against a predictor
`timescale 1ns / 1ps

module ray_circle_time_to_hit_tb;
  import rct_pkg::*;

  localparam int LATENCY    = 79;
  localparam int IDLE_LIMIT = 20000;

  typedef struct {
    logic [SB-1:0] status;
    logic [TB-1:0] tth;
  } hit_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   errors = 0;
  int   idle_cycles = 0;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  hit_t expected_hits[$];

  rct_query_if  q_if();
  rct_result_if r_if();

  ray_circle_time_to_hit u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (q_if.sink),
    .out_chan (r_if.source)
  );

  always #2 clk = ~clk;

  // exact floor square root of a 128-bit value
  function automatic logic [63:0] isqrt(logic [127:0] n);
    logic [63:0]  res;
    logic [63:0]  cand;
    logic [127:0] sq;
    res = '0;
    for (int b = 63; b >= 0; b--) begin
      cand = res | (64'd1 << b);
      sq = 128'(cand) * 128'(cand);
      if (sq <= n) res = cand;
    end
    return res;
  endfunction

  // time-to-hit predictor
  function automatic hit_t predict_hit(logic signed [CB-1:0] px, logic signed [CB-1:0] py,
                                       logic signed [CB-1:0] vx, logic signed [CB-1:0] vy,
                                       logic signed [CB-1:0] cx, logic signed [CB-1:0] cy,
                                       logic [RB-1:0] rad);
    hit_t         res;
    longint       dx, dy, h, a, dist2, r2, k;
    logic [127:0] hh, ak;
    logic [63:0]  s, num, q, t, rem;
    res.status = ST_NEVER;
    res.tth = '0;
    dx = longint'(px) - longint'(cx);
    dy = longint'(py) - longint'(cy);
    dist2 = dx * dx + dy * dy;
    r2 = longint'(rad) * longint'(rad);
    if (dist2 <= r2) begin
      res.status = ST_CONTACT;
      return res;
    end
    if (vx == 0 && vy == 0) return res;
    a = longint'(vx) * vx + longint'(vy) * vy;
    k = dist2 - r2;
    h = dx * vx + dy * vy;
    if (h >= 0) return res;
    hh = 128'(-h) * 128'(-h);
    ak = 128'(a) * 128'(k);
    if (hh < ak) return res;
    s = isqrt(hh - ak);
    num = 64'(-h) - s;
    q = num / 64'(a);
    rem = num % 64'(a);
    if (q > 64'(TIME_MAX)) t = 64'(TIME_MAX);
    else begin
      t = q;
      for (int i = 0; i < F; i++) begin
        rem = rem << 1;
        t = t << 1;
        if (rem >= 64'(a)) begin
          rem = rem - 64'(a);
          t = t | 64'd1;
        end
        if (t > 64'(TIME_MAX)) begin
          t = 64'(TIME_MAX);
          break;
        end
      end
    end
    res.status = ST_HIT;
    res.tth = t[TB-1:0];
    return res;
  endfunction

  // send one query transaction and record its expected result
  task automatic send_query(logic signed [CB-1:0] px, logic signed [CB-1:0] py,
                            logic signed [CB-1:0] vx, logic signed [CB-1:0] vy,
                            logic signed [CB-1:0] cx, logic signed [CB-1:0] cy,
                            logic [RB-1:0] rad);
    while ($urandom_range(99) < send_idle_pct) begin
      q_if.valid <= 1'b0;
      @(posedge clk);
    end
    q_if.valid           <= 1'b1;
    q_if.point_x         <= px;
    q_if.point_y         <= py;
    q_if.vel_x           <= vx;
    q_if.vel_y           <= vy;
    q_if.circle_center_x <= cx;
    q_if.circle_center_y <= cy;
    q_if.circle_radius   <= rad;
    do @(posedge clk); while (!q_if.ready);
    expected_hits.push_back(predict_hit(px, py, vx, vy, cx, cy, rad));
  endtask

  // receiver stalls
  always @(posedge clk) begin
    r_if.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // result checker
  always @(posedge clk) begin
    hit_t exp_hit;
    if (rst_n && r_if.valid && r_if.ready) begin
      if (expected_hits.size() == 0) begin
        $display("%0t: unexpected result status=%0d time=%0d", $time, r_if.hit_status,
                 r_if.time_to_hit);
        errors++;
      end else begin
        exp_hit = expected_hits.pop_front();
        if (r_if.hit_status !== exp_hit.status) begin
          $display("%0t: hit_status expected %0d actual %0d", $time, exp_hit.status,
                   r_if.hit_status);
          errors++;
        end
        if (r_if.time_to_hit !== exp_hit.tth) begin
          $display("%0t: time_to_hit expected %0d actual %0d", $time, exp_hit.tth,
                   r_if.time_to_hit);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((q_if.valid && q_if.ready) || (r_if.valid && r_if.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // stop sending and wait for every outstanding result
  task automatic wait_drain();
    q_if.valid <= 1'b0;
    while (expected_hits.size() != 0) @(posedge clk);
  endtask

  // extremes, contact, standing still, moving away, misses and hits
  task automatic test_directed();
    send_query(16'sd100, 16'sd0, 16'sd0, 16'sd0, 16'sd100, 16'sd0, 15'd0);
    send_query(16'sd10, 16'sd0, 16'sd5, 16'sd0, 16'sd0, 16'sd0, 15'd10);
    send_query(16'sd100, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 15'd10);
    send_query(-16'sd100, 16'sd50, 16'sd1, 16'sd0, 16'sd0, 16'sd0, 15'd10);
    send_query(-16'sd100, 16'sd0, -16'sd3, 16'sd0, 16'sd0, 16'sd0, 15'd10);
    send_query(-16'sd100, 16'sd10, 16'sd0, 16'sd7, 16'sd0, 16'sd0, 15'd10);
    send_query(-16'sd100, 16'sd0, 16'sd7, 16'sd0, 16'sd0, 16'sd0, 15'd10);
    send_query(-16'sd100, 16'sd10, 16'sd3, 16'sd0, 16'sd0, 16'sd0, 15'd10);
    send_query(-16'sd32768, -16'sd32768, 16'sd1, 16'sd1, 16'sd32767, 16'sd32767, 15'd0);
    send_query(-16'sd32768, 16'sd0, 16'sd1, 16'sd0, 16'sd32767, 16'sd0, 15'd1);
    send_query(-16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767,
               15'd32767);
    send_query(16'sd32767, 16'sd32767, -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768,
               15'd32767);
    send_query(16'sd32767, -16'sd32768, -16'sd1, 16'sd1, -16'sd32768, 16'sd32767, 15'd5);
    send_query(-16'sd1, -16'sd1, -16'sd1, -16'sd1, 16'sd0, 16'sd0, 15'd32767);
    send_query(16'sd0, 16'sd0, -16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767, 15'd32767);
    send_query(-16'sd20, 16'sd0, 16'sd1, 16'sd0, 16'sd0, 16'sd0, 15'd10);
    send_query(-16'sd11, 16'sd0, 16'sd3, 16'sd0, 16'sd0, 16'sd0, 15'd10);
  endtask

  // random queries, some aimed near the circle
  task automatic test_random(int count);
    logic signed [CB-1:0] px, py, vx, vy, cx, cy;
    logic [RB-1:0]        rad;
    int                   span;
    for (int i = 0; i < count; i++) begin
      cx = CB'($urandom); cy = CB'($urandom); rad = RB'($urandom);
      px = CB'($urandom); py = CB'($urandom); vx = CB'($urandom); vy = CB'($urandom);
      case ($urandom_range(3))
        0: ;
        1: begin
          span = 1 << $urandom_range(14);
          rad = RB'($urandom_range(span));
          cx = CB'(int'($urandom_range(16000)) - 8000);
          cy = CB'(int'($urandom_range(16000)) - 8000);
          px = CB'(int'(cx) + int'($urandom_range(4 * span)) - 2 * span);
          py = CB'(int'(cy) + int'($urandom_range(4 * span)) - 2 * span);
          vx = CB'((int'(cx) - int'(px)) / int'($urandom_range(1, 64)) +
                   int'($urandom_range(8)) - 4);
          vy = CB'((int'(cy) - int'(py)) / int'($urandom_range(1, 64)) +
                   int'($urandom_range(8)) - 4);
        end
        2: begin
          vx = CB'(int'($urandom_range(6)) - 3);
          vy = CB'(int'($urandom_range(6)) - 3);
          rad = RB'($urandom_range(200));
        end
        default: begin
          rad = RB'($urandom_range(1000));
          cx = CB'(int'(px) + int'($urandom_range(8000)) - 4000);
          cy = CB'(int'(py) + int'($urandom_range(8000)) - 4000);
          vx = CB'(int'($urandom_range(200)) - 100);
          vy = CB'(int'($urandom_range(200)) - 100);
        end
      endcase
      send_query(px, py, vx, vy, cx, cy, rad);
    end
  endtask

  initial begin
    q_if.valid = 1'b0;
    q_if.point_x = '0; q_if.point_y = '0; q_if.vel_x = '0; q_if.vel_y = '0;
    q_if.circle_center_x = '0; q_if.circle_center_y = '0; q_if.circle_radius = '0;
    r_if.ready = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_idle_pct = 38; recv_idle_pct = 65;
    test_directed();
    // hold off until the pipeline is empty
    wait_drain();
    test_random(210);
    send_idle_pct = 65; recv_idle_pct = 38;
    test_random(210);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random(210);
    wait_drain();
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0 && expected_hits.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
